### sv/asort_pkg.sv
// ----------------------------------------------------------------------------
// Ascending sorter package
// Shared constants and types for the sorting cell chain.
// ----------------------------------------------------------------------------
package asort_pkg;

    // Number of cells in the chain, which is also the largest set held.
    localparam int MAX_ITEMS = 16;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // One slot of the chain: an occupied flag and a signed element.
    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] val;
    } t_item;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        S_COLLECT = 3'b001,
        S_FLUSH   = 3'b010,
        S_EMIT    = 3'b100
    } t_state;

endpackage

### sv/ascending_sorter.sv
// ----------------------------------------------------------------------------
// Ascending sorter
// Collects a set of signed 32-bit values and returns them in ascending order.
// ----------------------------------------------------------------------------
// A set is written one value per transaction on the slave side; the
// transaction with tlast high closes it. Values enter a chain of MAX_ITEMS
// compare-exchange cells at one per cycle. After the closing transaction the
// chain settles while the last insertions ripple to their places, and then the
// set is shifted out of the head of the chain at one value per cycle on the
// master side while tready is not held low, smallest first, with tlast on the
// final value. No new set is taken while the chain settles or unloads; the
// output register lets the block take the next set while the final value of
// the previous one still waits. Values beyond MAX_ITEMS in one set are
// discarded and every result of that set carries tuser high. Equal values may
// appear in either order.
// ----------------------------------------------------------------------------
module ascending_sorter
    import asort_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Slave side. tdata: value[31:0].
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,
    input  logic              i_s_tlast,
    // Master side. tdata: sorted_value[31:0]; tuser: dropped[0].
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,
    output logic              o_m_tlast,
    output logic              o_m_tuser
);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic r_overflow, n_overflow;

    logic              r_m_tvalid, n_m_tvalid;
    logic [DATA_W-1:0] r_m_tdata,  n_m_tdata;
    logic              r_m_tlast,  n_m_tlast;
    logic              r_m_tuser,  n_m_tuser;

    t_item c_cur  [MAX_ITEMS];
    t_item c_pass [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] w_pass_vld;

    logic  w_s_hs;
    logic  w_room;
    logic  w_load;
    t_item w_head_in;

    assign o_s_tready = (r_state == S_COLLECT);
    assign w_s_hs     = i_s_tvalid && o_s_tready;
    assign w_room     = (r_count < CNT_W'(MAX_ITEMS));

    // New values enter the head cell only when there is room in the chain.
    assign w_head_in.vld = w_s_hs && w_room;
    assign w_head_in.val = $signed(i_s_tdata);

    // Unload one value whenever the output register is free or being taken.
    assign w_load = (r_state == S_EMIT) && (!r_m_tvalid || i_m_tready);

    // The cell chain. Each cell hands its spare element to the right while
    // inserting, and takes its right neighbour's element while unloading.
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_item w_left;
        t_item w_right;

        if (g == 0) begin : g_head
            assign w_left = w_head_in;
        end else begin : g_body
            assign w_left = c_pass[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_right.vld = 1'b0;
            assign w_right.val = '0;
        end else begin : g_inner
            assign w_right = c_cur[g+1];
        end

        asort_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_load),
            .i_left  (w_left),
            .i_right (w_right),
            .o_cur   (c_cur[g]),
            .o_pass  (c_pass[g])
        );

        assign w_pass_vld[g] = c_pass[g].vld;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_overflow = r_overflow;
        n_m_tvalid = r_m_tvalid;
        n_m_tdata  = r_m_tdata;
        n_m_tlast  = r_m_tlast;
        n_m_tuser  = r_m_tuser;

        if (r_m_tvalid && i_m_tready) begin
            n_m_tvalid = 1'b0;
        end

        unique case (r_state)
            S_COLLECT: begin
                if (w_s_hs) begin
                    if (w_room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                // Wait until no element is still travelling along the chain.
                if (w_pass_vld == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = c_cur[0].val;
                    n_m_tlast  = !c_cur[1].vld;
                    n_m_tuser  = r_overflow;
                    if (!c_cur[1].vld) begin
                        n_state    = S_COLLECT;
                        n_count    = '0;
                        n_overflow = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_COLLECT;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_tdata <= n_m_tdata;
        r_m_tlast <= n_m_tlast;
        r_m_tuser <= n_m_tuser;
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;
    assign o_m_tuser  = r_m_tuser;

endmodule

### sv/asort_cell.sv
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one element. While inserting it keeps the smaller of its own element
// and the one arriving from the left, and hands the larger one to the right.
// While unloading it takes the element of its right neighbour.
// ----------------------------------------------------------------------------
module asort_cell
    import asort_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_item i_left,
    input  t_item i_right,
    output t_item o_cur,
    output t_item o_pass
);

    t_item r_cur;
    t_item r_pass;
    t_item n_cur;
    t_item n_pass;

    always_comb begin
        n_cur      = r_cur;
        n_pass     = r_pass;
        n_pass.vld = 1'b0;
        if (i_shift) begin
            n_cur = i_right;
        end else if (i_left.vld) begin
            if (!r_cur.vld) begin
                n_cur = i_left;
            end else if (i_left.val < r_cur.val) begin
                n_cur  = i_left;
                n_pass = r_cur;
            end else begin
                n_pass = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur.vld  <= 1'b0;
            r_pass.vld <= 1'b0;
        end else begin
            r_cur  <= n_cur;
            r_pass <= n_pass;
        end
    end

    assign o_cur  = r_cur;
    assign o_pass = r_pass;

endmodule

### sv/asort_checker.sv
// ----------------------------------------------------------------------------
// Ascending sorter checker
// Port-level properties of the sorter, bound to the top level.
// ----------------------------------------------------------------------------
module asort_checker
    import asort_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic              i_s_tlast,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [DATA_W-1:0] o_m_tdata,
    input logic              o_m_tlast,
    input logic              o_m_tuser
);

    logic w_m_hs;
    logic r_in_set;
    logic signed [DATA_W-1:0] r_prev_val;
    logic r_prev_drop;

    assign w_m_hs = o_m_tvalid && i_m_tready;

    // Track the previous result of the set that is being delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_set <= 1'b0;
        end else if (w_m_hs) begin
            r_in_set <= !o_m_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_hs) begin
            r_prev_val  <= $signed(o_m_tdata);
            r_prev_drop <= o_m_tuser;
        end
    end

    // A closed set is sorted before any new value is taken.
    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input taken straight after the closing transaction");

    // Results within one set never decrease.
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_m_hs && r_in_set) |-> ($signed(o_m_tdata) >= r_prev_val))
        else $error("results of a set out of ascending order");

    // The loss flag is the same on every result of a set.
    a_drop_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_m_hs && r_in_set) |-> (o_m_tuser == r_prev_drop))
        else $error("loss flag changed within a set");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled result changed");

endmodule

bind ascending_sorter asort_checker u_asort_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
